// ===== design/tsli_pkg.sv =====
// ----------------------------------------------------------------------------
// tsli_pkg
// Shared types and constants for the calibration table search with linear
// interpolation: payload words, field widths, opcodes and register indexes.
// ----------------------------------------------------------------------------
package tsli_pkg;

  localparam int unsigned INTENSITY_BITS    = 16;
  localparam int unsigned T1_BITS           = 16;
  localparam int unsigned ENTRY_INDEX_BITS  = 8;
  localparam int unsigned TABLE_LENGTH_BITS = 9;
  localparam int unsigned CFG_DATA_BITS     = 16;
  localparam int unsigned TABLE_DEPTH_DEF   = 256;

  // weighted sum t1_hi*b + t1_lo*a needs one bit above the product width
  localparam int unsigned NUM_BITS = T1_BITS + INTENSITY_BITS + 1;

  localparam logic [TABLE_LENGTH_BITS-1:0] TABLE_LENGTH_RESET = 9'd256;
  localparam logic [T1_BITS-1:0]           NOT_FOUND_RESET    = 16'd20480;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic CFG_IDX_TABLE_LENGTH = 1'b0;
  localparam logic CFG_IDX_NOT_FOUND_T1 = 1'b1;

  typedef struct packed {
    logic                              opcode;
    logic [ENTRY_INDEX_BITS-1:0]       entry_index;
    logic signed [INTENSITY_BITS-1:0]  entry_intensity;
    logic [T1_BITS-1:0]                entry_t1;
    logic signed [INTENSITY_BITS-1:0]  pixel_intensity;
  } item_t;

  typedef struct packed {
    logic [T1_BITS-1:0] t1_value;
    logic               found;
  } result_t;

endpackage

// ===== design/tsli_div.sv =====
// ----------------------------------------------------------------------------
// tsli_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse loads
// the operands; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module tsli_div
  import tsli_pkg::*;
#(
  parameter int unsigned NUM_W = NUM_BITS,
  parameter int unsigned DEN_W = INTENSITY_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, q[NUM_W-1]};
    diff     = trial - {1'b0, den};
    ge       = (trial >= {1'b0, den});
    rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (count == CNT_W'(NUM_W - 1));
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        q     <= numer;
        den   <= denom;
      end else if (busy) begin
        rem   <= rem_next;
        q     <= {q[NUM_W-2:0], ge};
        count <= count + 1'b1;
        if (count == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quot = q;

endmodule

// ===== design/table_search_linear_interpolate_top.sv =====
// ----------------------------------------------------------------------------
// table_search_linear_interpolate_top
// Maps pixel intensities to T1 through a loaded calibration table, using
// linear interpolation between the first bracketing pair of entries.
// ----------------------------------------------------------------------------
// Usage:
//   item/item_valid/item_stall carries one input word; item.opcode selects a
//   table load or a pixel lookup. result/result_valid/result_stall returns one
//   word per pixel, none per load. cfg_we/cfg_index/cfg_data writes the
//   table_length (index 0) and not_found_t1 (index 1) registers; the user
//   is to write them only while idle, as the block does not enforce it.
//   A load is written into the table and the block stays ready for the
//   next item. A pixel scans the table memory one entry per cycle through
//   its single read port. A miss runs the scan to the last entry in use;
//   a hit goes on through the difference, multiply and sum steps and the
//   bit-serial divider. item_stall drops in the same cycle that the result
//   is raised, so the next item can be accepted while it waits.
//   One item is worked at a time; item_stall is high while a pixel is in
//   flight. A finished result waits in the output register while the next
//   item is accepted; if that register is still stalled when the next pixel
//   finishes, the block holds until the receiver takes the waiting word.
//   Reset clears the registers to table_length 256 and not_found_t1 5 s and
//   empties the output; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module table_search_linear_interpolate_top
  import tsli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  item_t                    item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output result_t                  result,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int unsigned IW  = INTENSITY_BITS;
  localparam int unsigned TW  = T1_BITS;
  localparam int unsigned PW  = TW + IW;
  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned LW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW  = (AW > ENTRY_INDEX_BITS) ? AW : ENTRY_INDEX_BITS;
  localparam int unsigned LXW = (LW > TABLE_LENGTH_BITS) ? LW : TABLE_LENGTH_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIFF,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [TABLE_LENGTH_BITS-1:0] table_length;
  logic [TW-1:0]                not_found_t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= TABLE_LENGTH_RESET;
      not_found_t1 <= NOT_FOUND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_TABLE_LENGTH: table_length <= cfg_data[TABLE_LENGTH_BITS-1:0];
        CFG_IDX_NOT_FOUND_T1: not_found_t1 <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // calibration table: {intensity, t1} per entry
  logic [IW+TW-1:0] table_mem [TABLE_DEPTH];
  logic [IW+TW-1:0] rdata;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic             wr_en;

  logic             accept;
  logic [XW-1:0]    idx_x;
  logic [LXW-1:0]   len_x;
  logic [LW-1:0]    len_eff;
  logic [AW-1:0]    cnt;
  logic [LW-1:0]    cnt_inc;
  logic [LW-1:0]    len_last;

  assign accept  = item_valid && !item_stall;
  assign idx_x   = XW'(item.entry_index);
  assign wr_en   = accept && (item.opcode == OP_LOAD) &&
                   ({1'b0, idx_x} < (XW+1)'(TABLE_DEPTH));
  assign waddr   = idx_x[AW-1:0];
  assign len_x   = LXW'(table_length);
  assign len_eff = (len_x > LXW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : len_x[LW-1:0];
  assign cnt_inc = LW'(cnt) + 1'b1;

  // read entry 0 outside the scan, otherwise the entry after the one now arriving
  always_comb begin
    raddr = '0;
    if (state == ST_SCAN && cnt_inc < LW'(TABLE_DEPTH)) begin
      raddr = cnt_inc[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[waddr] <= {item.entry_intensity, item.entry_t1};
    end
    rdata <= table_mem[raddr];
  end

  // scan and interpolation datapath
  logic signed [IW-1:0] px;
  logic signed [IW-1:0] prev_int;
  logic [TW-1:0]        prev_t1;
  logic signed [IW-1:0] cur_int;
  logic [TW-1:0]        cur_t1;
  logic signed [IW-1:0] hi_int;
  logic signed [IW-1:0] lo_int;
  logic [TW-1:0]        hi_t1;
  logic [TW-1:0]        lo_t1;
  logic [IW-1:0]        diff_a;
  logic [IW-1:0]        diff_b;
  logic [IW-1:0]        span;
  logic [PW-1:0]        prod_hi;
  logic [PW-1:0]        prod_lo;
  logic [NUM_BITS-1:0]  numer;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_BITS-1:0]  quot;
  logic [TW-1:0]        res_t1;
  logic                 res_found;
  logic                 hit;
  logic signed [IW:0]   a_full;
  logic signed [IW:0]   b_full;
  logic signed [IW:0]   s_full;

  assign cur_int = rdata[IW+TW-1:TW];
  assign cur_t1  = rdata[TW-1:0];
  assign hit     = (px < prev_int) && (px > cur_int);
  assign a_full  = {hi_int[IW-1], hi_int} - {px[IW-1], px};
  assign b_full  = {px[IW-1], px} - {lo_int[IW-1], lo_int};
  assign s_full  = {hi_int[IW-1], hi_int} - {lo_int[IW-1], lo_int};

  tsli_div #(
    .NUM_W (NUM_BITS),
    .DEN_W (IW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (span),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      div_start    <= 1'b0;
    end else begin
      div_start <= (state == ST_SUM);
      if (result_valid && !result_stall && state != ST_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && item.opcode == OP_PIXEL) begin
            px        <= item.pixel_intensity;
            cnt       <= '0;
            len_last  <= len_eff - 1'b1;
            res_t1    <= not_found_t1;
            res_found <= 1'b0;
            state     <= (len_eff < LW'(2)) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          prev_int <= cur_int;
          prev_t1  <= cur_t1;
          if (cnt != '0 && hit) begin
            hi_int <= prev_int;
            hi_t1  <= prev_t1;
            lo_int <= cur_int;
            lo_t1  <= cur_t1;
            state  <= ST_DIFF;
          end else if (LW'(cnt) == len_last) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt_inc[AW-1:0];
          end
        end
        ST_DIFF: begin
          diff_a <= a_full[IW-1:0];
          diff_b <= b_full[IW-1:0];
          span   <= s_full[IW-1:0];
          state  <= ST_MUL;
        end
        ST_MUL: begin
          prod_hi <= hi_t1 * diff_b;
          prod_lo <= lo_t1 * diff_a;
          state   <= ST_SUM;
        end
        ST_SUM: begin
          numer <= NUM_BITS'(prod_hi) + NUM_BITS'(prod_lo);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            // clamp to the largest T1 code
            res_t1    <= (quot > NUM_BITS'({TW{1'b1}})) ? {TW{1'b1}} : quot[TW-1:0];
            res_found <= 1'b1;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            result.t1_value <= res_t1;
            result.found    <= res_found;
            result_valid    <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign item_stall = (state != ST_IDLE);

`ifndef ASSERT_OFF
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    accept && item.opcode == OP_LOAD |=> state == ST_IDLE)
    else $error("load word left the idle state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide step");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> LW'(cnt) <= len_last)
    else $error("scan pointer passed the last table entry");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result raised without a finished lookup");
`endif

endmodule
